/* sv/bdad_pkg.sv */
package bdad_pkg;

  // Sizes
  localparam int MAX_DIGITS = 10;
  localparam int VALUE_BITS = 32;
  localparam int VALUE_W    = 32;
  localparam int NUMD_W     = 4;
  localparam int CHAR_W     = 6;
  localparam int BCD_W      = 4;

  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CMP_W     = (CNT_W > NUMD_W) ? CNT_W : NUMD_W;

  // ASCII '0' kept to six bits
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);

  typedef logic [BCD_W-1:0] bcd_t;
  typedef bcd_t [MAX_DIGITS-1:0] digits_t;

  // Converter sequencer
  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_DONE
  } conv_state_t;

  // Hand-off from converter to emitter
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } emit_ld_t;

endpackage

/* sv/bdad_in_if.sv */
interface bdad_in_if;
  import bdad_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [NUMD_W-1:0]   num_digits;

  modport source (output valid, value, num_digits, input ready);
  modport sink   (input valid, value, num_digits, output ready);
endinterface

/* sv/bdad_out_if.sv */
interface bdad_out_if;
  import bdad_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, digit_char, last_digit, input ready);
  modport sink   (input valid, digit_char, last_digit, output ready);
endinterface

/* sv/binary_to_decimal_ascii_digits.sv */
// Channel  Dir  Payload                          Handshake
// in_ch    in   value[31:0], num_digits[3:0]     valid/ready
// out_ch   out  digit_char[5:0], last_digit      valid/ready
//
// A value is shifted MSB first into a row of ten BCD cells, one bit per
// cycle. Digits then move to an emitter that sends one character per cycle
// while the output is ready, as the cells already convert the next item.
// Reset (rst_n, synchronous, active low) empties both stages.
// A stalled output holds the digits; the converter waits with its result.
module binary_to_decimal_ascii_digits
  import bdad_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bdad_in_if.sink    in_ch,
  bdad_out_if.source out_ch
);

  conv_state_t            state_r, state_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CMP_W-1:0]       nd_ext;
  logic [CNT_W-1:0]       cnt_sat;
  logic                   in_acc;
  logic                   shift_en;
  logic                   last_bit;
  logic                   ld_ready;
  emit_ld_t               ld;
  digits_t                digits;
  logic [MAX_DIGITS:0]    carry;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign last_bit = (bit_cnt_r == BIT_CNT_W'(VALUE_BITS - 1));

  // saturate the digit count
  assign nd_ext  = CMP_W'(in_ch.num_digits);
  assign cnt_sat = (nd_ext > CMP_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : CNT_W'(nd_ext);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE:  if (in_acc) state_nxt = CV_SHIFT;
      CV_SHIFT: if (last_bit) state_nxt = CV_DONE;
      CV_DONE: begin
        if (in_acc) begin
          state_nxt = CV_SHIFT;
        end else if (ld_ready) begin
          state_nxt = CV_IDLE;
        end
      end
      default:  state_nxt = CV_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    shift_en    = 1'b0;
    ld.valid    = 1'b0;
    ld.count    = cnt_r;
    case (state_r)
      CV_IDLE:  in_ch.ready = 1'b1;
      CV_SHIFT: shift_en = 1'b1;
      CV_DONE: begin
        ld.valid    = 1'b1;
        in_ch.ready = ld_ready;
      end
      default: ;
    endcase
  end

  // value shifter and bit counter
  always_comb begin
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    bit_cnt_nxt = bit_cnt_r;
    if (in_acc) begin
      val_nxt     = in_ch.value[VALUE_BITS-1:0];
      cnt_nxt     = cnt_sat;
      bit_cnt_nxt = '0;
    end else if (shift_en) begin
      val_nxt     = {val_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    cnt_r     <= cnt_nxt;
    bit_cnt_r <= bit_cnt_nxt;
  end

  // row of BCD cells, least significant digit first
  assign carry[0] = val_r[VALUE_BITS-1];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    bdad_cell u_cell (
      .clk     (clk),
      .clear   (in_acc),
      .shift   (shift_en),
      .bit_in  (carry[i]),
      .bit_out (carry[i+1]),
      .digit   (digits[i])
    );
  end

  // character emitter
  bdad_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_digits (digits),
    .ld_ready  (ld_ready),
    .out_ch    (out_ch)
  );

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == CV_SHIFT) && (bit_cnt_r == '0))
    else $error("accepted item did not start conversion");

  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_SHIFT && last_bit) |=> (state_r == CV_DONE))
    else $error("conversion did not end after the last bit");

  a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (ld.valid && ld_ready && ld.count != '0) |=> out_ch.valid)
    else $error("loaded digits not presented");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CV_SHIFT) |-> !in_ch.ready)
    else $error("input ready during conversion");

endmodule

/* sv/bdad_cell.sv */
module bdad_cell
  import bdad_pkg::*;
(
  input  logic clk,
  input  logic clear,
  input  logic shift,
  input  logic bit_in,
  output logic bit_out,
  output bcd_t digit
);

  bcd_t digit_r;
  bcd_t digit_nxt;
  bcd_t adj;

  // add-3 correction ahead of the doubling
  assign adj     = (digit_r >= BCD_W'(5)) ? (digit_r + BCD_W'(3)) : digit_r;
  assign bit_out = adj[BCD_W-1];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (clear) begin
      digit_nxt = '0;
    end else if (shift) begin
      digit_nxt = {adj[BCD_W-2:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

/* sv/bdad_emit.sv */
module bdad_emit
  import bdad_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  emit_ld_t          ld,
  input  digits_t           ld_digits,
  output logic              ld_ready,
  bdad_out_if.source        out_ch
);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  digits_t          digs_r, digs_nxt;
  logic             out_fire;
  logic             at_last;
  logic [CNT_W-1:0] cnt_m1;

  assign at_last  = (idx_r == '0);
  assign out_fire = busy_r && out_ch.ready;
  assign ld_ready = !busy_r || (out_fire && at_last);
  assign cnt_m1   = ld.count - CNT_W'(1);

  // next digit pointer, counts down toward the least significant digit
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    digs_nxt = digs_r;
    if (ld.valid && ld_ready) begin
      busy_nxt = (ld.count != '0);
      idx_nxt  = cnt_m1[IDX_W-1:0];
      digs_nxt = ld_digits;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    digs_r <= digs_nxt;
  end

  // character output
  assign out_ch.valid      = busy_r;
  assign out_ch.digit_char = ASCII_ZERO + CHAR_W'(digs_r[idx_r]);
  assign out_ch.last_digit = at_last;

endmodule
